FILE: sv/ptlc_pkg.sv
// ---------------------------------------------------------------------------
// ptlc_pkg - shared types and constants
// Lamp, flag, result and configuration types plus register map constants
// for the pedestrian traffic light controller.
// ---------------------------------------------------------------------------
`default_nettype none

package ptlc_pkg;

    // Field widths
    localparam int PHASE_W       = 13;
    localparam int BLINK_W       = 12;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;
    localparam int DEF_TIMER_W   = 16;

    // Multiples of a phase length need two extra bits
    localparam int PHASE_MULT_W  = PHASE_W + 2;

    // Register reset values
    localparam logic [PHASE_W-1:0] PHASE_TICKS_RST      = PHASE_W'(5000);
    localparam logic [BLINK_W-1:0] BLINK_HALF_TICKS_RST = BLINK_W'(1000);

    // Register indexes (paddr[2])
    localparam logic REG_PHASE_TICKS      = 1'b0;
    localparam logic REG_BLINK_HALF_TICKS = 1'b1;

    // Lamp drives, car green in bit 0
    typedef struct packed {
        logic walk_red;
        logic walk_yellow;
        logic walk_green;
        logic car_red;
        logic car_yellow;
        logic car_green;
    } lamps_t;

    // Car phase seen last in car mode
    typedef struct packed {
        logic red;
        logic yellow;
        logic green;
    } car_flags_t;

    // One result word: lamps in bits 0..5, walk mode in bit 6
    typedef struct packed {
        logic   walk_mode;
        lamps_t lamps;
    } result_t;

    // Configuration handed to the sequencer
    typedef struct packed {
        logic [PHASE_W-1:0] phase_ticks;
        logic [BLINK_W-1:0] blink_half_ticks;
    } cfg_t;

endpackage

`default_nettype wire

FILE: sv/ptlc_cfg_regs.sv
// ---------------------------------------------------------------------------
// ptlc_cfg_regs - APB configuration registers
// Holds phase_ticks (0x0) and blink_half_ticks (0x4); zero-wait access.
// ---------------------------------------------------------------------------
`default_nettype none

module ptlc_cfg_regs
    import ptlc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [PHASE_W-1:0] phase_ticks_reg;
    logic [BLINK_W-1:0] blink_half_ticks_reg;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg      <= PHASE_TICKS_RST;
            blink_half_ticks_reg <= BLINK_HALF_TICKS_RST;
        end else if (wr_en) begin
            case (reg_sel)
                REG_PHASE_TICKS:      phase_ticks_reg      <= pwdata[PHASE_W-1:0];
                REG_BLINK_HALF_TICKS: blink_half_ticks_reg <= pwdata[BLINK_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_sel)
            REG_PHASE_TICKS:      prdata = APB_DATA_W'(phase_ticks_reg);
            REG_BLINK_HALF_TICKS: prdata = APB_DATA_W'(blink_half_ticks_reg);
            default:              prdata = '0;
        endcase
    end

    assign cfg.phase_ticks      = phase_ticks_reg;
    assign cfg.blink_half_ticks = blink_half_ticks_reg;

endmodule

`default_nettype wire

FILE: sv/ptlc_seq.sv
// ---------------------------------------------------------------------------
// ptlc_seq - light sequencer
// Timer, blink divider, mode and lamp registers with the single-pass
// next-state logic; one step per enabled cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ptlc_seq
    import ptlc_pkg::*;
#(
    parameter int TIMER_WIDTH = DEF_TIMER_W
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic step_en,
    input  wire logic tick_pulse,
    input  wire logic button_press,
    input  wire cfg_t cfg,
    output result_t   result
);

    localparam int CMP_W = (TIMER_WIDTH > PHASE_MULT_W) ? TIMER_WIDTH : PHASE_MULT_W;

    logic [TIMER_WIDTH-1:0] elapsed_reg,  elapsed_next;
    logic [BLINK_W-1:0]     blink_cnt_reg, blink_cnt_next;
    logic                   blink_lvl_reg, blink_lvl_next;
    logic                   ped_reg,      ped_next;
    car_flags_t             flags_reg,    flags_next;
    lamps_t                 lamps_reg,    lamps_next;

    logic [PHASE_W-1:0]     p;
    logic [BLINK_W-1:0]     h;
    logic [CMP_W-1:0]       p1, p2, p3, p4;
    logic [BLINK_W:0]       blink_inc;

    // Zero settings act as one; phase boundaries
    assign p  = (cfg.phase_ticks == '0) ? PHASE_W'(1) : cfg.phase_ticks;
    assign h  = (cfg.blink_half_ticks == '0) ? BLINK_W'(1) : cfg.blink_half_ticks;
    assign p1 = CMP_W'(p);
    assign p2 = CMP_W'({p, 1'b0});
    assign p3 = CMP_W'({p, 1'b0}) + CMP_W'(p);
    assign p4 = CMP_W'({p, 2'b00});
    assign blink_inc = {1'b0, blink_cnt_reg} + (BLINK_W+1)'(1);

    // Next-state logic for one step
    always_comb begin
        logic [CMP_W-1:0] t;
        logic             finish;
        logic             car_dec;

        elapsed_next   = elapsed_reg;
        blink_cnt_next = blink_cnt_reg;
        blink_lvl_next = blink_lvl_reg;
        ped_next       = ped_reg;
        flags_next     = flags_reg;
        lamps_next     = lamps_reg;
        finish         = 1'b0;
        car_dec        = 1'b0;

        // A press in car mode restarts the timer, otherwise a tick advances it
        if (!ped_reg && button_press) begin
            ped_next       = 1'b1;
            elapsed_next   = '0;
            blink_cnt_next = '0;
            blink_lvl_next = 1'b1;
        end else if (tick_pulse) begin
            if (elapsed_reg != '1) begin
                elapsed_next = elapsed_reg + TIMER_WIDTH'(1);
            end
            if (blink_inc >= {1'b0, h}) begin
                blink_cnt_next = '0;
                blink_lvl_next = ~blink_lvl_reg;
            end else begin
                blink_cnt_next = blink_inc[BLINK_W-1:0];
            end
        end

        t = CMP_W'(elapsed_next);

        // Pedestrian sequence decode
        if (ped_next) begin
            if (flags_reg.red) begin
                if (t < p1) begin
                    lamps_next.car_red     = 1'b1;
                    lamps_next.walk_green  = 1'b1;
                    lamps_next.walk_yellow = 1'b0;
                    lamps_next.walk_red    = 1'b0;
                end else if (t < p2) begin
                    lamps_next.car_red     = 1'b0;
                    lamps_next.car_yellow  = blink_lvl_next;
                    lamps_next.walk_yellow = blink_lvl_next;
                end else if (t < p3) begin
                    lamps_next.car_yellow  = 1'b0;
                    lamps_next.walk_yellow = 1'b0;
                    lamps_next.walk_green  = 1'b0;
                    lamps_next.walk_red    = 1'b1;
                    lamps_next.car_green   = 1'b1;
                end else begin
                    finish = 1'b1;
                end
            end else begin
                if (t < p1) begin
                    lamps_next.car_green   = 1'b0;
                    lamps_next.walk_red    = 1'b1;
                    lamps_next.car_yellow  = blink_lvl_next;
                    lamps_next.walk_yellow = blink_lvl_next;
                end else if (t < p2) begin
                    lamps_next.car_yellow  = 1'b0;
                    lamps_next.walk_yellow = 1'b0;
                    lamps_next.walk_red    = 1'b0;
                    lamps_next.walk_green  = 1'b1;
                    lamps_next.car_red     = 1'b1;
                end else if (t < p3) begin
                    lamps_next.car_red     = 1'b0;
                    lamps_next.car_yellow  = blink_lvl_next;
                    lamps_next.walk_yellow = blink_lvl_next;
                end else if (t < p4) begin
                    lamps_next.car_yellow  = 1'b0;
                    lamps_next.walk_yellow = 1'b0;
                    lamps_next.walk_green  = 1'b0;
                    lamps_next.walk_red    = 1'b1;
                    lamps_next.car_green   = 1'b1;
                end else begin
                    finish = 1'b1;
                end
            end
        end else begin
            car_dec = 1'b1;
        end

        // End of pedestrian sequence: back to car mode at tick 0
        if (finish) begin
            lamps_next.walk_red  = 1'b0;
            lamps_next.car_green = 1'b0;
            ped_next             = 1'b0;
            elapsed_next         = '0;
            blink_cnt_next       = '0;
            blink_lvl_next       = 1'b1;
            car_dec              = 1'b1;
        end

        // Car cycle decode, wrapping after four phases
        if (car_dec) begin
            if (CMP_W'(elapsed_next) >= p4) begin
                elapsed_next   = '0;
                blink_cnt_next = '0;
                blink_lvl_next = 1'b1;
            end
            t = CMP_W'(elapsed_next);
            if (t < p1) begin
                lamps_next.car_green  = 1'b1;
                lamps_next.car_yellow = 1'b0;
                lamps_next.car_red    = 1'b0;
                flags_next            = '{red: 1'b0, yellow: 1'b0, green: 1'b1};
            end else if (t < p2 || t >= p3) begin
                lamps_next.car_green  = 1'b0;
                lamps_next.car_red    = 1'b0;
                lamps_next.car_yellow = blink_lvl_next;
                flags_next            = '{red: 1'b0, yellow: 1'b1, green: 1'b0};
            end else begin
                lamps_next.car_red    = 1'b1;
                lamps_next.car_green  = 1'b0;
                lamps_next.car_yellow = 1'b0;
                flags_next            = '{red: 1'b1, yellow: 1'b0, green: 1'b0};
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            elapsed_reg   <= '0;
            blink_cnt_reg <= '0;
            blink_lvl_reg <= 1'b1;
            ped_reg       <= 1'b0;
            flags_reg     <= '0;
            lamps_reg     <= '0;
        end else if (step_en) begin
            elapsed_reg   <= elapsed_next;
            blink_cnt_reg <= blink_cnt_next;
            blink_lvl_reg <= blink_lvl_next;
            ped_reg       <= ped_next;
            flags_reg     <= flags_next;
            lamps_reg     <= lamps_next;
        end
    end

    assign result.walk_mode = ped_next;
    assign result.lamps     = lamps_next;

endmodule

`default_nettype wire

FILE: sv/pedestrian_traffic_light_controller_core.sv
// ---------------------------------------------------------------------------
// pedestrian_traffic_light_controller_core - top level
// Stream-in tick/button words, stream-out lamp words, APB configuration.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per event, tick_pulse and button_press.
//   m_ channel: one word per input word, the six lamp drives and walk mode
//   as they stand after that event.
//   APB: phase_ticks at 0x0, blink_half_ticks at 0x4, zero wait states.
//   Write configuration only while no words are in flight.
// Path: an accepted word passes through two register stages (input
//   register, then result register) before it shows on m_.
// Throughput: one word per cycle while m_tready is high; each step is a single pass through the
//   sequencer's compare-and-select logic between the two registers.
// Stall: while m_tready is low the result register holds and the input
//   register still takes one more word; s_tready then drops until the
//   result is taken.
// Reset: both stages empty, lamps off, car mode, timer cleared, registers
//   at their defaults (5000 and 1000 ticks).
// ---------------------------------------------------------------------------
`default_nettype none

module pedestrian_traffic_light_controller_core
    import ptlc_pkg::*;
#(
    parameter int TIMER_WIDTH = DEF_TIMER_W
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // s_tdata: [0] tick_pulse, [1] button_press, [7:2] zero
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,
    // m_tdata: [0] car_green_on, [1] car_yellow_on, [2] car_red_on,
    //          [3] walk_green_on, [4] walk_yellow_on, [5] walk_red_on,
    //          [6] walk_mode, [7] zero
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    cfg_t    cfg;
    result_t result;

    logic    in_valid_reg;
    logic    in_tick_reg;
    logic    in_btn_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    logic    out_free;
    logic    step_en;

    ptlc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ptlc_seq #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .tick_pulse   (in_tick_reg),
        .button_press (in_btn_reg),
        .cfg          (cfg),
        .result       (result)
    );

    // Stage handshake
    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_tick_reg <= s_tdata[0];
            in_btn_reg  <= s_tdata[1];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};

endmodule

`default_nettype wire

FILE: sv/ptlc_checker.sv
// ---------------------------------------------------------------------------
// ptlc_checker - port-level checks
// Concurrent assertions on the top level's stream ports, bound to the core.
// ---------------------------------------------------------------------------
`default_nettype none

module ptlc_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // Output stage is empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // An accepted word has a result once it has passed the input and result registers
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> ##1 m_tvalid)
        else $error("result missing after accepted word");

    // Input only backs up when the output is stalled
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("s_tready low without output stall");

    // Car mode lights at most one of green/yellow/red
    a_car_lamps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[6]) |-> $onehot0(m_tdata[2:0]))
        else $error("conflicting car lamps in car mode");

endmodule

bind pedestrian_traffic_light_controller_core ptlc_checker u_ptlc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: verif/tb_ptlc_lamp_sb_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_ptlc_lamp_sb_pkg - lamp sequence scoreboard
// Predicts the lamp word that follows every accepted tick/button word and
// checks the words leaving the controller against those predictions.
// ---------------------------------------------------------------------------

package tb_ptlc_lamp_sb_pkg;

    import ptlc_pkg::*;

    class lamp_scoreboard;

        // Mirrored configuration
        logic [PHASE_W-1:0]     phase_ticks;
        logic [BLINK_W-1:0]     blink_half;

        // Mirrored sequencer state
        logic [DEF_TIMER_W-1:0] elapsed;
        logic [BLINK_W-1:0]     blink_cnt;
        logic                   blink_lvl;
        logic                   walk_active;
        car_flags_t             flags;
        lamps_t                 lamps;

        result_t                lamp_words_due[$];
        string                  field_names[7];
        int                     errors;
        int                     checked;
        int                     walk_starts;

        function new();
            phase_ticks = PHASE_TICKS_RST;
            blink_half  = BLINK_HALF_TICKS_RST;
            restart_timer();
            walk_active = 1'b0;
            flags       = '0;
            lamps       = '0;
            errors      = 0;
            checked     = 0;
            walk_starts = 0;
            field_names = '{"car_green_on", "car_yellow_on", "car_red_on",
                            "walk_green_on", "walk_yellow_on", "walk_red_on",
                            "walk_mode"};
        endfunction

        function void set_reg(logic idx, logic [APB_DATA_W-1:0] val);
            if (idx == REG_PHASE_TICKS) begin
                phase_ticks = val[PHASE_W-1:0];
            end else begin
                blink_half = val[BLINK_W-1:0];
            end
        endfunction

        function int pending();
            return lamp_words_due.size();
        endfunction

        // A zero phase length behaves as one tick
        function int unsigned phase_len();
            return (phase_ticks == 0) ? 1 : phase_ticks;
        endfunction

        function void restart_timer();
            elapsed   = '0;
            blink_cnt = '0;
            blink_lvl = 1'b1;
        endfunction

        // One tick: timer saturates, blink divider toggles at half period
        function void advance_time();
            int unsigned half;
            int unsigned nxt;
            half = (blink_half == 0) ? 1 : blink_half;
            nxt  = blink_cnt + 1;
            if (elapsed != '1) begin
                elapsed = elapsed + 1'b1;
            end
            if (nxt >= half) begin
                blink_cnt = '0;
                blink_lvl = ~blink_lvl;
            end else begin
                blink_cnt = nxt[BLINK_W-1:0];
            end
        endfunction

        // Car cycle: green, blinking yellow, red, blinking yellow
        function void car_lamps();
            int unsigned p;
            int unsigned t;
            p = phase_len();
            if (elapsed >= 4 * p) begin
                restart_timer();
            end
            t     = elapsed;
            flags = '0;
            if (t < p) begin
                lamps.car_green  = 1'b1;
                lamps.car_yellow = 1'b0;
                lamps.car_red    = 1'b0;
                flags.green      = 1'b1;
            end else if (t < 2 * p || t >= 3 * p) begin
                lamps.car_green  = 1'b0;
                lamps.car_red    = 1'b0;
                lamps.car_yellow = blink_lvl;
                flags.yellow     = 1'b1;
            end else begin
                lamps.car_red    = 1'b1;
                lamps.car_green  = 1'b0;
                lamps.car_yellow = 1'b0;
                flags.red        = 1'b1;
            end
        endfunction

        // Sequence over: back to car mode, tick 0 decoded in the same step
        function void end_walk();
            lamps.walk_red  = 1'b0;
            lamps.car_green = 1'b0;
            walk_active     = 1'b0;
            restart_timer();
            car_lamps();
        endfunction

        function void walk_lamps();
            int unsigned p;
            int unsigned t;
            p = phase_len();
            t = elapsed;
            if (flags.red) begin
                // entered during red: walk green, both blinking, car green
                if (t < p) begin
                    lamps.car_red     = 1'b1;
                    lamps.walk_green  = 1'b1;
                    lamps.walk_yellow = 1'b0;
                    lamps.walk_red    = 1'b0;
                end else if (t < 2 * p) begin
                    lamps.car_red     = 1'b0;
                    lamps.car_yellow  = blink_lvl;
                    lamps.walk_yellow = blink_lvl;
                end else if (t < 3 * p) begin
                    lamps.car_yellow  = 1'b0;
                    lamps.walk_yellow = 1'b0;
                    lamps.walk_green  = 1'b0;
                    lamps.walk_red    = 1'b1;
                    lamps.car_green   = 1'b1;
                end else begin
                    end_walk();
                end
            end else begin
                // entered during green/yellow: blink, walk, blink, car green
                if (t < p) begin
                    lamps.car_green   = 1'b0;
                    lamps.walk_red    = 1'b1;
                    lamps.car_yellow  = blink_lvl;
                    lamps.walk_yellow = blink_lvl;
                end else if (t < 2 * p) begin
                    lamps.car_yellow  = 1'b0;
                    lamps.walk_yellow = 1'b0;
                    lamps.walk_red    = 1'b0;
                    lamps.walk_green  = 1'b1;
                    lamps.car_red     = 1'b1;
                end else if (t < 3 * p) begin
                    lamps.car_red     = 1'b0;
                    lamps.car_yellow  = blink_lvl;
                    lamps.walk_yellow = blink_lvl;
                end else if (t < 4 * p) begin
                    lamps.car_yellow  = 1'b0;
                    lamps.walk_yellow = 1'b0;
                    lamps.walk_green  = 1'b0;
                    lamps.walk_red    = 1'b1;
                    lamps.car_green   = 1'b1;
                end else begin
                    end_walk();
                end
            end
        endfunction

        // Accepted input word: step the mirror and queue the lamp word
        function void note_input(logic tick, logic btn);
            result_t w;
            if (!walk_active && btn) begin
                // press wins over a tick in the same word
                walk_active = 1'b1;
                walk_starts++;
                restart_timer();
            end else if (tick) begin
                advance_time();
            end
            if (walk_active) begin
                walk_lamps();
            end else begin
                car_lamps();
            end
            w.walk_mode = walk_active;
            w.lamps     = lamps;
            lamp_words_due.push_back(w);
        endfunction

        function void check_result(logic [7:0] word);
            result_t want;
            if (lamp_words_due.size() == 0) begin
                $error("m_tdata: no lamp word expected, got %02h", word);
                errors++;
                return;
            end
            want = lamp_words_due.pop_front();
            checked++;
            for (int b = 0; b < 7; b++) begin
                if (word[b] !== want[b]) begin
                    $error("%s: expected %0b, got %0b", field_names[b], want[b], word[b]);
                    errors++;
                end
            end
        endfunction

    endclass

endpackage

FILE: verif/tb_pedestrian_traffic_light_controller_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_pedestrian_traffic_light_controller_core - controller testbench
// Streams tick/button words into the controller with random gaps and
// backpressure, reprograms the phase and blink lengths over APB between
// runs, and checks every lamp word against a cycle-free prediction.
// ---------------------------------------------------------------------------

module tb_pedestrian_traffic_light_controller_core;

    import ptlc_pkg::*;
    import tb_ptlc_lamp_sb_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata: [0] tick_pulse, [1] button_press, [7:2] zero
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // m_tdata: [0] car_green_on .. [5] walk_red_on, [6] walk_mode, [7] zero
    logic [7:0]            m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Set during one run to switch off all gaps and stalls
    logic                  steady_flow;
    int                    settings_used;

    lamp_scoreboard        sb;

    pedestrian_traffic_light_controller_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result side: random stalls, checked at the rising edge
    always @(negedge aclk) begin
        m_tready <= aresetn && (steady_flow || $urandom_range(0, 99) >= 23);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    // One input word; called and returns at a falling edge
    task automatic send_word(input logic tick, input logic btn);
        while (!steady_flow && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, btn, tick};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(tick, btn);
        @(negedge aclk);
    endtask

    // Hold the sender until every predicted lamp word is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    // Write one register, then read it back
    task automatic apb_write(input logic idx, input logic [APB_DATA_W-1:0] val);
        logic [APB_DATA_W-1:0] kept;
        kept = (idx == REG_PHASE_TICKS) ? (val & APB_DATA_W'((1 << PHASE_W) - 1))
                                        : (val & APB_DATA_W'((1 << BLINK_W) - 1));
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== kept) begin
            $error("prdata: expected %0d, got %0d", kept, prdata);
            sb.errors++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input int unsigned phase, input int unsigned half);
        drain();
        apb_write(REG_PHASE_TICKS, phase);
        apb_write(REG_BLINK_HALF_TICKS, half);
        settings_used++;
    endtask

    // Mostly ticks, occasional presses; enough to walk through every phase
    task automatic random_words(input int n);
        for (int i = 0; i < n; i++) begin
            send_word($urandom_range(0, 99) < 85, $urandom_range(0, 99) < 5);
        end
    endtask

    initial begin
        sb            = new();
        settings_used = 1;
        steady_flow   = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: press with no car phase seen yet, press+tick in walk
        send_word(1'b0, 1'b1);
        send_word(1'b1, 1'b1);
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b0);

        // Two-tick phases: finish the walk, reach red, press with a tick
        set_config(2, 1);
        repeat (11) send_word(1'b1, 1'b0);
        send_word(1'b1, 1'b1);
        send_word(1'b0, 1'b0);
        repeat (6) send_word(1'b1, 1'b0);
        repeat (2) send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b1);

        // Zero settings, two-tick phases, maximum, then a spread of short settings
        set_config(0, 0);
        random_words(100);
        set_config(2, 1);
        random_words(300);
        set_config(8191, 4095);
        random_words(100);
        for (int k = 0; k < 5; k++) begin
            set_config($urandom_range(2, 12), $urandom_range(1, 6));
            steady_flow = (k == 2);
            random_words(200);
            steady_flow = 1'b0;
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("tb: %0d lamp words checked across %0d register settings",
                 sb.checked, settings_used);
        $display("tb: %0d pedestrian sequences started", sb.walk_starts);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
